@@ rtl/sfr_pkg.sv @@
`default_nettype none
package sfr_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] REG_HEADER   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXP_LEN  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 2'd3;

  localparam logic [7:0] HEADER_RST  = 8'hAA;
  localparam logic [7:0] SOURCE_RST  = 8'h12;
  localparam logic [5:0] EXP_LEN_RST = 6'd60;
  localparam logic [9:0] TIMEOUT_RST = 10'd1000;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic KIND_WORD   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Parser report for the accepted byte.
  typedef struct packed {
    logic store_we;
    logic frame_good;
  } parse_stat_t;

endpackage
`default_nettype wire

@@ rtl/sfr_ram.sv @@
`default_nettype none
module sfr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

@@ rtl/sfr_parser.sv @@
`default_nettype none
module sfr_parser #(
  parameter int unsigned STORE_DEPTH = 64
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           byte_en_i,
  input  wire logic [7:0]                     byte_i,
  input  wire logic [7:0]                     header_i,
  input  wire logic [7:0]                     source_i,
  input  wire logic [5:0]                     exp_len_i,
  output sfr_pkg::parse_stat_t                stat_o,
  output logic      [$clog2(STORE_DEPTH)-1:0] store_addr_o
);

  localparam int unsigned AW = $clog2(STORE_DEPTH);
  localparam int unsigned LW = (AW > 6) ? AW : 6;
  localparam logic [8:0]  CAPACITY = 9'(STORE_DEPTH - 4);

  typedef enum logic [4:0] {
    PH_IDLE    = 5'b00001,
    PH_SOURCE  = 5'b00010,
    PH_LENGTH  = 5'b00100,
    PH_PAYLOAD = 5'b01000,
    PH_CHECK   = 5'b10000
  } phase_e;

  phase_e        phase_q, phase_d;
  logic [AW-1:0] rem_q, rem_d;
  logic [AW-1:0] wpos_q, wpos_d;
  logic [7:0]    sum_q, sum_d;
  logic [AW-1:0] len;
  logic [7:0]    sum_next;

  assign sum_next = sum_q + byte_i;
  assign len      = wpos_q - AW'(3);

  always_comb begin
    phase_d      = phase_q;
    rem_d        = rem_q;
    wpos_d       = wpos_q;
    sum_d        = sum_q;
    stat_o       = '0;
    store_addr_o = wpos_q;
    if (byte_en_i) begin
      unique case (phase_q)
        PH_IDLE: begin
          if (byte_i == header_i) begin
            stat_o.store_we = 1'b1;
            store_addr_o    = AW'(0);
            sum_d           = byte_i;
            phase_d         = PH_SOURCE;
          end
        end
        PH_SOURCE: begin
          if (byte_i == source_i) begin
            stat_o.store_we = 1'b1;
            store_addr_o    = AW'(1);
            sum_d           = sum_next;
            phase_d         = PH_LENGTH;
          end else begin
            phase_d = PH_IDLE;
          end
        end
        PH_LENGTH: begin
          // drop empty frames and frames longer than STORE_DEPTH - 4 bytes
          if (byte_i == 8'd0 || {1'b0, byte_i} > CAPACITY) begin
            phase_d = PH_IDLE;
          end else begin
            stat_o.store_we = 1'b1;
            store_addr_o    = AW'(2);
            sum_d           = sum_next;
            rem_d           = byte_i[AW-1:0];
            wpos_d          = AW'(3);
            phase_d         = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          stat_o.store_we = 1'b1;
          store_addr_o    = wpos_q;
          wpos_d          = wpos_q + AW'(1);
          sum_d           = sum_next;
          rem_d           = rem_q - AW'(1);
          if (rem_d == '0) begin
            phase_d = PH_CHECK;
          end
        end
        PH_CHECK: begin
          phase_d = PH_IDLE;
          stat_o.frame_good = (byte_i == sum_q) && (LW'(len) == LW'(exp_len_i));
        end
        default: phase_d = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      rem_q   <= '0;
      wpos_q  <= '0;
      sum_q   <= '0;
    end else begin
      phase_q <= phase_d;
      rem_q   <= rem_d;
      wpos_q  <= wpos_d;
      sum_q   <= sum_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/serial_frame_receiver_with_checksum.sv @@
// Channel  | Signals                                         | Direction
// ---------+-------------------------------------------------+----------
// in       | in_valid_i, in_ready_o, opcode_i, byte_value_i  | request in
// out      | out_valid_o, out_ready_i, result_kind_o,        | request out
//          | word_index_o, word_value_o, last_word_o,        |
//          | link_online_o                                   |
// cfg      | cfg_we_i, cfg_index_i, cfg_data_i               | write only
//
// A byte or a tick is taken in one handshake; a tick's status request shows the next cycle.
// A good frame of the expected length is then read out word by word (4 store reads per
// word, each a read step and a shift step, then one push step), paced by the
// single read port of the frame store; in_ready_o is low meanwhile.
// A stalled output holds the sequencer in its push step. Reset is asynchronous.
`default_nettype none
module serial_frame_receiver_with_checksum #(
  parameter int unsigned STORE_DEPTH = 64,
  parameter int unsigned WORD_COUNT  = 15
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic                            opcode_i,
  input  wire logic [7:0]                      byte_value_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic                                 result_kind_o,
  output logic        [3:0]                    word_index_o,
  output logic signed [31:0]                   word_value_o,
  output logic                                 last_word_o,
  output logic                                 link_online_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [sfr_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [sfr_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned AW = $clog2(STORE_DEPTH);
  localparam logic [3:0]  LAST_IDX = 4'(WORD_COUNT - 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD   = 4'b0010,
    S_SH   = 4'b0100,
    S_PUSH = 4'b1000
  } seq_e;

  logic [7:0] header_q, source_q;
  logic [5:0] exp_len_q;
  logic [9:0] timeout_q;
  logic [9:0] silence_q, silence_d;

  seq_e        seq_q, seq_d;
  logic [3:0]  widx_q, widx_d;
  logic [1:0]  bsel_q, bsel_d;
  logic        mask_q, mask_d;
  logic [31:0] acc_q, acc_d;

  logic        out_valid_q, out_load;
  logic        kind_d, last_d, online_d;
  logic [3:0]  idx_d;
  logic [31:0] value_d;
  logic        kind_q, last_q, online_q;
  logic [3:0]  idx_q;
  logic [31:0] value_q;

  logic                 in_acc, byte_en, tick_en, rd_en, out_free;
  logic [5:0]           offset;
  logic [8:0]           rd_pos;
  logic [7:0]           rd_data;
  logic [AW-1:0]        store_addr;
  sfr_pkg::parse_stat_t stat;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (seq_q == S_IDLE) && out_free;
  assign in_acc     = in_valid_i && in_ready_o;
  assign byte_en    = in_acc && (opcode_i == sfr_pkg::OP_BYTE);
  assign tick_en    = in_acc && (opcode_i == sfr_pkg::OP_TICK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q  <= sfr_pkg::HEADER_RST;
      source_q  <= sfr_pkg::SOURCE_RST;
      exp_len_q <= sfr_pkg::EXP_LEN_RST;
      timeout_q <= sfr_pkg::TIMEOUT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        sfr_pkg::REG_HEADER:  header_q  <= cfg_data_i[7:0];
        sfr_pkg::REG_SOURCE:  source_q  <= cfg_data_i[7:0];
        sfr_pkg::REG_EXP_LEN: exp_len_q <= cfg_data_i[5:0];
        sfr_pkg::REG_TIMEOUT: timeout_q <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  sfr_parser #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_en_i    (byte_en),
    .byte_i       (byte_value_i),
    .header_i     (header_q),
    .source_i     (source_q),
    .exp_len_i    (exp_len_q),
    .stat_o       (stat),
    .store_addr_o (store_addr)
  );

  assign offset = {widx_q, bsel_q};
  assign rd_pos = 9'(offset) + 9'd3;

  sfr_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (stat.store_we),
    .waddr_i (store_addr),
    .wdata_i (byte_value_i),
    .re_i    (rd_en),
    .raddr_i (rd_pos[AW-1:0]),
    .rdata_o (rd_data)
  );

  always_comb begin
    seq_d     = seq_q;
    widx_d    = widx_q;
    bsel_d    = bsel_q;
    mask_d    = mask_q;
    acc_d     = acc_q;
    rd_en     = 1'b0;
    silence_d = silence_q;
    out_load  = 1'b0;
    kind_d    = sfr_pkg::KIND_WORD;
    idx_d     = 4'd0;
    value_d   = 32'd0;
    last_d    = 1'b0;
    online_d  = 1'b0;
    unique case (seq_q)
      S_IDLE: begin
        if (tick_en) begin
          out_load = 1'b1;
          kind_d   = sfr_pkg::KIND_STATUS;
          if (silence_q < timeout_q) begin
            silence_d = silence_q + 10'd1;
            online_d  = 1'b1;
          end
        end
        if (stat.frame_good) begin
          silence_d = '0;
          widx_d    = '0;
          bsel_d    = '0;
          seq_d     = S_RD;
        end
      end
      S_RD: begin
        rd_en  = 1'b1;
        // bytes past the frame's payload read as zero
        mask_d = offset < exp_len_q;
        seq_d  = S_SH;
      end
      S_SH: begin
        acc_d  = {acc_q[23:0], mask_q ? rd_data : 8'h00};
        bsel_d = bsel_q + 2'd1;
        seq_d  = (bsel_q == 2'd3) ? S_PUSH : S_RD;
      end
      S_PUSH: begin
        if (out_free) begin
          out_load = 1'b1;
          idx_d    = widx_q;
          value_d  = acc_q;
          last_d   = (widx_q == LAST_IDX);
          widx_d   = widx_q + 4'd1;
          seq_d    = (widx_q == LAST_IDX) ? S_IDLE : S_RD;
        end
      end
      default: seq_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q       <= S_IDLE;
      widx_q      <= '0;
      bsel_q      <= '0;
      mask_q      <= 1'b0;
      silence_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      seq_q     <= seq_d;
      widx_q    <= widx_d;
      bsel_q    <= bsel_d;
      mask_q    <= mask_d;
      silence_q <= silence_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (out_load) begin
      kind_q   <= kind_d;
      idx_q    <= idx_d;
      value_q  <= value_d;
      last_q   <= last_d;
      online_q <= online_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = kind_q;
  assign word_index_o  = idx_q;
  assign word_value_o  = value_q;
  assign last_word_o   = last_q;
  assign link_online_o = online_q;

endmodule
`default_nettype wire

@@ rtl/sfr_chk.sv @@
`default_nettype none
module sfr_chk #(
  parameter int unsigned WORD_COUNT = 15
) (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           in_valid_i,
  input wire logic                           in_ready_o,
  input wire logic                           opcode_i,
  input wire logic                           out_valid_o,
  input wire logic                           out_ready_i,
  input wire logic                           result_kind_o,
  input wire logic        [3:0]              word_index_o,
  input wire logic signed [31:0]             word_value_o,
  input wire logic                           last_word_o,
  input wire logic                           link_online_o
);

  // status requests carry only the online flag
  a_status_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == sfr_pkg::KIND_STATUS
      |-> word_index_o == 4'd0 && word_value_o == 32'sd0 && !last_word_o)
    else $error("status request carries word fields");

  a_word_offline: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == sfr_pkg::KIND_WORD |-> !link_online_o)
    else $error("word request flags online");

  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == sfr_pkg::KIND_WORD && last_word_o
      |-> word_index_o == 4'(WORD_COUNT - 1))
    else $error("last word at wrong index");

  a_tick_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && opcode_i == sfr_pkg::OP_TICK
      |=> out_valid_o && result_kind_o == sfr_pkg::KIND_STATUS)
    else $error("tick without status request");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(word_value_o))
    else $error("stalled output changed");

endmodule

bind serial_frame_receiver_with_checksum sfr_chk #(
  .WORD_COUNT (WORD_COUNT)
) u_sfr_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .opcode_i      (opcode_i),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .result_kind_o (result_kind_o),
  .word_index_o  (word_index_o),
  .word_value_o  (word_value_o),
  .last_word_o   (last_word_o),
  .link_online_o (link_online_o)
);
`default_nettype wire

@@ tb/tb_serial_frame_receiver_with_checksum.sv @@
module tb_serial_frame_receiver_with_checksum;
  import sfr_pkg::*;

  localparam int STORE_DEPTH = 64;
  localparam int WORD_COUNT  = 15;
  localparam int CAPACITY    = STORE_DEPTH - 4;
  localparam int HOLD_CYCLES = 300;
  localparam int DIR_ROWS    = 29;

  typedef enum logic [2:0] {ST_HUNT, ST_SRC, ST_LEN, ST_BODY, ST_SUM} rx_state_e;

  typedef struct packed {
    logic               kind;
    logic [3:0]         idx;
    logic signed [31:0] value;
    logic               last;
    logic               online;
  } result_t;

  typedef struct packed {
    bit                    is_reg;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    logic                  op;
    logic [7:0]            b;
    bit                    typed;
    logic                  online;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  logic opcode_i;
  logic [7:0] byte_value_i;
  logic out_valid_o;
  logic out_ready_i;
  logic result_kind_o;
  logic [3:0] word_index_o;
  logic signed [31:0] word_value_o;
  logic last_word_o;
  logic link_online_o;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  serial_frame_receiver_with_checksum i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .byte_value_i  (byte_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_kind_o (result_kind_o),
    .word_index_o  (word_index_o),
    .word_value_o  (word_value_o),
    .last_word_o   (last_word_o),
    .link_online_o (link_online_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mirror of the receiver: registers and parser state
  logic [7:0] cfg_header;
  logic [7:0] cfg_source;
  logic [5:0] cfg_len;
  logic [9:0] cfg_limit;
  rx_state_e  rx_state;
  logic [7:0] rx_left;
  logic [7:0] rx_wptr;
  logic [7:0] rx_sum;
  logic [7:0] rx_store [STORE_DEPTH];
  logic [9:0] rx_silence;

  result_t pending_out [$];
  int      n_fail;
  int      n_sent;
  int      src_idle;
  int      snk_stall;
  int      hold_ticket;
  row_t    dir_rows [DIR_ROWS];

  function automatic int parse_and_decode(input logic op, input logic [7:0] b,
                                          output result_t res [WORD_COUNT]);
    logic [31:0] v;
    logic [7:0]  flen;
    int          w;
    int          k;
    int          off;
    if (op == OP_TICK) begin
      res[0] = '{KIND_STATUS, 4'd0, 32'sd0, 1'b0, 1'b0};
      if (rx_silence < cfg_limit) begin
        rx_silence = rx_silence + 10'd1;
        res[0].online = 1'b1;
      end
      return 1;
    end
    case (rx_state)
      ST_HUNT: begin
        if (b == cfg_header) begin
          rx_store[0] = b;
          rx_sum = b;
          rx_state = ST_SRC;
        end
      end
      ST_SRC: begin
        if (b == cfg_source) begin
          rx_store[1] = b;
          rx_sum = rx_sum + b;
          rx_state = ST_LEN;
        end else begin
          rx_state = ST_HUNT;
        end
      end
      ST_LEN: begin
        if (b == 8'd0 || b > CAPACITY) begin
          rx_state = ST_HUNT;
        end else begin
          rx_store[2] = b;
          rx_sum = rx_sum + b;
          rx_left = b;
          rx_wptr = 8'd3;
          rx_state = ST_BODY;
        end
      end
      ST_BODY: begin
        if (rx_wptr < STORE_DEPTH) rx_store[rx_wptr] = b;
        rx_wptr = rx_wptr + 8'd1;
        rx_sum = rx_sum + b;
        rx_left = rx_left - 8'd1;
        if (rx_left == 8'd0) rx_state = ST_SUM;
      end
      default: begin
        flen = rx_wptr - 8'd3;
        rx_state = ST_HUNT;
        if (b == rx_sum && flen == {2'b00, cfg_len}) begin
          rx_silence = '0;
          // bytes past the frame's length read as zero
          for (w = 0; w < WORD_COUNT; w++) begin
            v = '0;
            for (k = 0; k < 4; k++) begin
              off = w * 4 + k;
              v = {v[23:0], (off < int'(cfg_len)) ? rx_store[3 + off] : 8'h00};
            end
            res[w] = '{KIND_WORD, 4'(w), v, (w == WORD_COUNT - 1), 1'b0};
          end
          return WORD_COUNT;
        end
      end
    endcase
    return 0;
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic row_t row_byte(input logic [7:0] b);
    return '{1'b0, '0, '0, OP_BYTE, b, 1'b0, 1'b0};
  endfunction

  function automatic row_t row_tick(input logic online);
    return '{1'b0, '0, '0, OP_TICK, 8'h00, 1'b1, online};
  endfunction

  function automatic row_t row_reg(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] val);
    return '{1'b1, idx, val, OP_BYTE, 8'h00, 1'b0, 1'b0};
  endfunction

  task automatic send_req(input logic op, input logic [7:0] b,
                          input bit typed = 1'b0, input logic typed_online = 1'b0);
    result_t res [WORD_COUNT];
    int      n;
    int      i;
    while ($urandom_range(99) < src_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    opcode_i     <= op;
    byte_value_i <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    n_sent++;
    n = parse_and_decode(op, b, res);
    if (typed) begin
      pending_out.push_back('{KIND_STATUS, 4'd0, 32'sd0, 1'b0, typed_online});
    end else begin
      for (i = 0; i < n; i++) pending_out.push_back(res[i]);
    end
  endtask

  // Hold the input side until every expected request has come out
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_HEADER:  cfg_header = val[7:0];
      REG_SOURCE:  cfg_source = val[7:0];
      REG_EXP_LEN: cfg_len    = val[5:0];
      REG_TIMEOUT: cfg_limit  = val[9:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_phase(input logic [7:0] hdr, input logic [7:0] src,
                           input logic [5:0] len, input logic [9:0] lim,
                           input int s_idle, input int r_stall);
    drain();
    write_reg(REG_HEADER, 10'(hdr));
    write_reg(REG_SOURCE, 10'(src));
    write_reg(REG_EXP_LEN, 10'(len));
    write_reg(REG_TIMEOUT, lim);
    src_idle  = s_idle;
    snk_stall = r_stall;
  endtask

  task automatic send_frame(input int len, input bit bad_sum);
    logic [7:0] sum;
    logic [7:0] b;
    int         i;
    sum = cfg_header + cfg_source + 8'(len);
    send_req(OP_BYTE, cfg_header);
    send_req(OP_BYTE, cfg_source);
    send_req(OP_BYTE, 8'(len));
    for (i = 0; i < len; i++) begin
      b = rand_byte();
      sum = sum + b;
      send_req(OP_BYTE, b);
    end
    if (bad_sum) sum = sum ^ 8'($urandom_range(1, 255));
    send_req(OP_BYTE, sum);
  endtask

  task automatic run_mix(input int count);
    int         start;
    int         pick;
    int         len;
    logic [7:0] b;
    start = n_sent;
    while (n_sent - start < count) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        send_frame(cfg_len, 1'b0);
      end else if (pick < 65) begin
        // good frame that is not the decoded length
        len = ($urandom_range(7) == 0) ? CAPACITY : $urandom_range(1, 8);
        if (len == cfg_len) len = (len == CAPACITY) ? len - 1 : len + 1;
        send_frame(len, 1'b0);
      end else if (pick < 73) begin
        send_frame(($urandom_range(1) != 0) ? int'(cfg_len) : $urandom_range(1, 6), 1'b1);
      end else if (pick < 78) begin
        b = 8'($urandom_range(255));
        if (b == cfg_source) b = ~b;
        send_req(OP_BYTE, cfg_header);
        send_req(OP_BYTE, b);
      end else if (pick < 83) begin
        send_req(OP_BYTE, cfg_header);
        send_req(OP_BYTE, cfg_source);
        send_req(OP_BYTE, ($urandom_range(1) != 0) ? 8'h00 : 8'($urandom_range(CAPACITY + 1, 255)));
      end else if (pick < 93) begin
        repeat ($urandom_range(1, 4)) send_req(OP_TICK, 8'($urandom_range(255)));
      end else begin
        send_req(OP_BYTE, 8'($urandom_range(255)));
      end
    end
  endtask

  // Receiver: random stalls plus a long hold whenever the ticket moves
  initial begin
    int hold_left;
    int seen;
    hold_left = 0;
    seen = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_ticket != seen) begin
        seen = hold_ticket;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= snk_stall);
      end
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_out.size() == 0) begin
        $error("result_kind: expected nothing, got %0d", result_kind_o);
        n_fail++;
      end else begin
        want = pending_out.pop_front();
        if (result_kind_o !== want.kind) begin
          $error("result_kind: expected %0d, got %0d", want.kind, result_kind_o);
          n_fail++;
        end
        if (word_index_o !== want.idx) begin
          $error("word_index: expected %0d, got %0d", want.idx, word_index_o);
          n_fail++;
        end
        if (word_value_o !== want.value) begin
          $error("word_value: expected %0d, got %0d", want.value, word_value_o);
          n_fail++;
        end
        if (last_word_o !== want.last) begin
          $error("last_word: expected %0d, got %0d", want.last, last_word_o);
          n_fail++;
        end
        if (link_online_o !== want.online) begin
          $error("link_online: expected %0d, got %0d", want.online, link_online_o);
          n_fail++;
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int i;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    opcode_i     = OP_BYTE;
    byte_value_i = 8'h00;
    cfg_we_i     = 1'b0;
    cfg_index_i  = REG_HEADER;
    cfg_data_i   = '0;
    n_fail       = 0;
    n_sent       = 0;
    src_idle     = 0;
    snk_stall    = 0;
    hold_ticket  = 0;
    cfg_header   = HEADER_RST;
    cfg_source   = SOURCE_RST;
    cfg_len      = EXP_LEN_RST;
    cfg_limit    = TIMEOUT_RST;
    rx_state     = ST_HUNT;
    rx_left      = '0;
    rx_wptr      = '0;
    rx_sum       = '0;
    rx_silence   = '0;

    dir_rows = '{
      row_tick(1'b1),
      // idle noise, then a wrong source that is itself the header value
      row_byte(8'h00), row_byte(8'hFF),
      row_byte(8'hAA), row_byte(8'hAA), row_byte(8'h12),
      // zero length, then one over capacity
      row_byte(8'hAA), row_byte(8'h12), row_byte(8'h00),
      row_byte(8'hAA), row_byte(8'h12), row_byte(8'(CAPACITY + 1)),
      row_reg(REG_EXP_LEN, 10'd1), row_reg(REG_TIMEOUT, 10'd2),
      // silence count saturates at the limit
      row_tick(1'b1), row_tick(1'b0), row_tick(1'b0),
      // one-byte frame: zero fill behind the most negative word
      row_byte(8'hAA), row_byte(8'h12), row_byte(8'h01), row_byte(8'h80),
      row_byte(8'h3D),
      row_tick(1'b1),
      // checksum mismatch
      row_byte(8'hAA), row_byte(8'h12), row_byte(8'h01), row_byte(8'h7F),
      row_byte(8'h00),
      row_tick(1'b1)
    };

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < DIR_ROWS; i++) begin
      if (dir_rows[i].is_reg) begin
        drain();
        write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
      end else begin
        send_req(dir_rows[i].op, dir_rows[i].b, dir_rows[i].typed, dir_rows[i].online);
      end
    end

    set_phase(8'hAA, 8'h12, 6'd4, 10'd20, 0, 0);
    run_mix(40);
    set_phase(8'h00, 8'hFF, 6'd1, 10'd5, 56, 0);
    run_mix(40);
    set_phase(8'hFF, 8'h00, 6'd60, 10'd1023, 0, 56);
    run_mix(20);
    // lower the limit below a count that may already be higher
    set_phase(8'h55, 8'hA5, 6'd8, 10'd1, 37, 37);
    run_mix(40);

    // hold off the output while frames keep coming so the input stalls
    set_phase(8'h3C, 8'hC3, 6'd12, 10'd1023, 0, 0);
    hold_ticket <= hold_ticket + 1;
    repeat (2) send_frame(cfg_len, 1'b0);
    repeat (6) send_req(OP_TICK, 8'($urandom_range(255)));
    run_mix(10);

    drain();
    repeat (20) @(posedge clk_i);
    if (n_fail == 0 && pending_out.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
